// ===== src/chm_pkg.sv =====
// Shared package of the chained hash map engine: sizes, codes, request,
// response and pool-entry types. No dependencies.
package chm_pkg;

   localparam int NUM_BUCKETS  = 1024;
   localparam int POOL_ENTRIES = 4096;
   localparam int KEY_BITS     = 32;
   localparam int VALUE_BITS   = 16;
   localparam int BKT_IN_BITS  = 10;

   localparam int BKT_BITS = $clog2(NUM_BUCKETS);
   localparam int IDX_BITS = $clog2(POOL_ENTRIES);
   localparam int PTR_BITS = IDX_BITS + 1;
   localparam int CNT_BITS = $clog2(POOL_ENTRIES + 1);

   localparam logic [PTR_BITS-1:0] NIL_PTR = '1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_MISS = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [KEY_BITS-1:0]    key;
      logic [BKT_IN_BITS-1:0] bucket_index;
      logic [VALUE_BITS-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] result_value;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [PTR_BITS-1:0]   next;
   } entry_type;

   function automatic logic is_entry(input logic [PTR_BITS-1:0] ptr);
      return ptr < PTR_BITS'(POOL_ENTRIES);
   endfunction

endpackage

// ===== src/chm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/chained_hash_map_engine_unit.sv =====
// Top level of the chained hash map engine: request sequencer over two RAMs.
// Depends on chm_pkg and chm_ram.
// Key-to-value map built as a hash table with separate chaining. Bucket heads
// live in one RAM, pool entries (key, value, next) in another; free entries
// are kept on a LIFO list threaded through their next fields, topped up from
// a counter of never-used entries. After reset a clearing pass nulls all
// NUM_BUCKETS (1024) bucket heads while requests are held off. One request
// is worked at a time, one RAM read per cycle. A lookup that hits walks the
// chain up to the matching entry; a miss walks the whole chain; a delete adds
// the S_UNLINK step for returning the entry. An insert walks to the chain
// tail, with the extra S_POP step when the entry comes off the free list. The
// chain walk through the entry RAM runs one entry per cycle. The response is
// held in an output register, so a stalled response never loses data.
module chained_hash_map_engine_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  chm_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output chm_pkg::rsp_type rsp_data
);
   import chm_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_HEAD   = 9'b000000100,
      S_WALK   = 9'b000001000,
      S_UNLINK = 9'b000010000,
      S_POP    = 9'b000100000,
      S_ALLOC  = 9'b001000000,
      S_TAIL   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [BKT_BITS-1:0] clr_ff, clr_in;
   req_type             req_ff, req_in;
   logic [PTR_BITS-1:0] cur_ff, cur_in;
   logic [PTR_BITS-1:0] prev_ff, prev_in;
   entry_type           prev_word_ff, prev_word_in;
   logic [PTR_BITS-1:0] e_ff, e_in;
   logic [PTR_BITS-1:0] free_head_ff, free_head_in;
   logic [CNT_BITS-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_BITS-1:0] fresh_ff, fresh_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                bkt_we;
   logic [BKT_BITS-1:0] bkt_waddr, bkt_raddr;
   logic [PTR_BITS-1:0] bkt_wdata, bkt_rdata;
   logic                ent_we;
   logic [IDX_BITS-1:0] ent_waddr, ent_raddr;
   entry_type           ent_wdata, ent_rdata;
   logic                req_accept;
   logic [BKT_BITS-1:0] req_bkt;

   chm_ram #(.WIDTH(PTR_BITS), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
      .clock  (clock),
      .wr_en  (bkt_we),
      .wr_addr(bkt_waddr),
      .wr_data(bkt_wdata),
      .rd_addr(bkt_raddr),
      .rd_data(bkt_rdata)
   );

   chm_ram #(.WIDTH($bits(entry_type)), .DEPTH(POOL_ENTRIES)) u_entry_ram (
      .clock  (clock),
      .wr_en  (ent_we),
      .wr_addr(ent_waddr),
      .wr_data(ent_wdata),
      .rd_addr(ent_raddr),
      .rd_data(ent_rdata)
   );

   // take requests only in idle; the clearing pass holds them off
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   // bucket count is a power of two: modulo is the low bits
   assign req_bkt    = req_data.bucket_index[BKT_BITS-1:0];
   assign bkt_raddr  = req_bkt;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_word_in = prev_word_ff;
      e_in         = e_ff;
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      fresh_in     = fresh_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bkt_we       = 1'b0;
      bkt_waddr    = req_ff.bucket_index[BKT_BITS-1:0];
      bkt_wdata    = e_ff;
      ent_we       = 1'b0;
      ent_waddr    = e_ff[IDX_BITS-1:0];
      ent_wdata    = '{key: req_ff.key, value: req_ff.value, next: NIL_PTR};
      ent_raddr    = cur_ff[IDX_BITS-1:0];

      case (state_ff)
         S_CLEAR: begin
            // null one bucket head per cycle
            bkt_we    = 1'b1;
            bkt_waddr = clr_ff;
            bkt_wdata = NIL_PTR;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == BKT_BITS'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cur_in  = bkt_rdata;
            prev_in = NIL_PTR;
            case (req_ff.opcode)
               OP_LOOKUP, OP_DELETE: begin
                  if (!is_entry(bkt_rdata)) begin
                     res_in   = '{found: 1'b0, result_value: '0, status: STS_MISS};
                     state_in = S_DONE;
                  end else begin
                     ent_raddr = bkt_rdata[IDX_BITS-1:0];
                     state_in  = S_WALK;
                  end
               end
               OP_INSERT: begin
                  if (free_cnt_ff == '0) begin
                     res_in   = '{found: 1'b0, result_value: '0, status: STS_FULL};
                     state_in = S_DONE;
                  end else if (is_entry(free_head_ff)) begin
                     ent_raddr = free_head_ff[IDX_BITS-1:0];
                     state_in  = S_POP;
                  end else begin
                     e_in        = PTR_BITS'(fresh_ff);
                     fresh_in    = fresh_ff + 1'b1;
                     free_cnt_in = free_cnt_ff - 1'b1;
                     state_in    = S_ALLOC;
                  end
               end
               default: begin
                  res_in   = '{found: 1'b0, result_value: '0, status: STS_OK};
                  state_in = S_DONE;
               end
            endcase
         end
         S_POP: begin
            // pop the free-list top; its next names the new top
            e_in         = free_head_ff;
            free_head_in = ent_rdata.next;
            free_cnt_in  = free_cnt_ff - 1'b1;
            state_in     = S_ALLOC;
         end
         S_ALLOC: begin
            ent_we = 1'b1;
            res_in = '{found: 1'b0, result_value: '0, status: STS_OK};
            if (!is_entry(cur_ff)) begin
               bkt_we   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (!is_entry(ent_rdata.next)) begin
               ent_we    = 1'b1;
               ent_waddr = cur_ff[IDX_BITS-1:0];
               ent_wdata = '{key: ent_rdata.key, value: ent_rdata.value, next: e_ff};
               state_in  = S_DONE;
            end else begin
               cur_in    = ent_rdata.next;
               ent_raddr = ent_rdata.next[IDX_BITS-1:0];
            end
         end
         S_WALK: begin
            if (ent_rdata.key == req_ff.key) begin
               res_in = '{found: 1'b1, result_value: ent_rdata.value, status: STS_OK};
               if (req_ff.opcode == OP_DELETE) begin
                  // unlink from predecessor or bucket head
                  if (is_entry(prev_ff)) begin
                     ent_we    = 1'b1;
                     ent_waddr = prev_ff[IDX_BITS-1:0];
                     ent_wdata = '{key: prev_word_ff.key, value: prev_word_ff.value,
                                   next: ent_rdata.next};
                  end else begin
                     bkt_we    = 1'b1;
                     bkt_wdata = ent_rdata.next;
                  end
                  state_in = S_UNLINK;
               end else begin
                  state_in = S_DONE;
               end
            end else if (!is_entry(ent_rdata.next)) begin
               res_in   = '{found: 1'b0, result_value: '0, status: STS_MISS};
               state_in = S_DONE;
            end else begin
               prev_in      = cur_ff;
               prev_word_in = ent_rdata;
               cur_in       = ent_rdata.next;
               ent_raddr    = ent_rdata.next[IDX_BITS-1:0];
            end
         end
         S_UNLINK: begin
            // push the freed entry onto the free list
            ent_we       = 1'b1;
            ent_waddr    = cur_ff[IDX_BITS-1:0];
            ent_wdata    = '{key: req_ff.key, value: res_ff.result_value,
                             next: free_head_ff};
            free_head_in = cur_ff;
            if (free_cnt_ff < CNT_BITS'(POOL_ENTRIES)) begin
               free_cnt_in = free_cnt_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= NIL_PTR;
         free_cnt_ff  <= CNT_BITS'(POOL_ENTRIES);
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_word_ff <= prev_word_in;
      e_ff         <= e_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("request taken during clearing pass");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= CNT_BITS'(POOL_ENTRIES))
      else $error("free count above pool size");
   a_alloc_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC) |-> is_entry(e_ff))
      else $error("allocated entry is null");
   a_accept_head: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_HEAD))
      else $error("accepted request did not start");
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CNT_BITS'(POOL_ENTRIES))
      else $error("fresh entry counter past pool");
`endif

endmodule
